### hdl/lcrle_pkg.sv
// Shared types and constants for the logic capture run-length compressor.
package lcrle_pkg;

  localparam int STORE_DEPTH_DEFAULT = 16384;
  localparam int RING_LIMIT          = 16384;

  localparam int ADDR_W  = 14;
  localparam int WORD_W  = 16;
  localparam int COUNT_W = 15;
  localparam int LEN_W   = 15;
  localparam int PADDR_W = 5;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_BUFFER_WORDS  = 3'd0;
  localparam logic [2:0] REG_POST_TRIGGER  = 3'd1;
  localparam logic [2:0] REG_WIDE_MODE     = 3'd2;
  localparam logic [2:0] REG_TRIGGER_MASK  = 3'd3;
  localparam logic [2:0] REG_TRIGGER_LEVEL = 3'd4;

  localparam logic [LEN_W-1:0]   BUFFER_WORDS_RESET = 15'd16384;
  localparam logic [WORD_W-1:0]  FLAG_WIDE          = 16'h8000;
  localparam logic [WORD_W-1:0]  FLAG_NARROW        = 16'h0080;
  localparam logic [COUNT_W-1:0] MAX_WIDE           = 15'h7fff;
  localparam logic [COUNT_W-1:0] MAX_NARROW         = 15'h007f;
  localparam logic [WORD_W-1:0]  MASK_WIDE          = 16'hffff;
  localparam logic [WORD_W-1:0]  MASK_NARROW        = 16'h00ff;
  localparam logic [LEN_W-1:0]   POST_TRIGGER_MASK  = 15'h7ffe;

  typedef struct packed {
    logic [LEN_W-1:0]  buffer_words;
    logic [LEN_W-1:0]  post_trigger_words;
    logic              wide_mode;
    logic [WORD_W-1:0] trigger_mask;
    logic [WORD_W-1:0] trigger_level;
    logic              budget_load;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] value_addr;
    logic [ADDR_W-1:0] count_addr;
    logic [WORD_W-1:0] value_word;
    logic [WORD_W-1:0] count_word;
    logic              done;
  } pair_t;

endpackage

### hdl/lcrle_cfg.sv
// APB register file for the compressor settings.
module lcrle_cfg
  import lcrle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [LEN_W-1:0]  buffer_words;
  logic [LEN_W-1:0]  post_trigger_words;
  logic              wide_mode;
  logic [WORD_W-1:0] trigger_mask;
  logic [WORD_W-1:0] trigger_level;
  logic              budget_load;
  logic              wr_en;
  logic [2:0]        reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_words       <= BUFFER_WORDS_RESET;
      post_trigger_words <= '0;
      wide_mode          <= 1'b1;
      trigger_mask       <= '0;
      trigger_level      <= '0;
      budget_load        <= 1'b0;
    end else begin
      budget_load <= 1'b0;
      if (wr_en) begin
        unique case (reg_index)
          REG_BUFFER_WORDS:  buffer_words <= pwdata[LEN_W-1:0];
          REG_POST_TRIGGER: begin
            post_trigger_words <= pwdata[LEN_W-1:0] & POST_TRIGGER_MASK;
            budget_load        <= 1'b1;
          end
          REG_WIDE_MODE:     wide_mode     <= pwdata[0];
          REG_TRIGGER_MASK:  trigger_mask  <= pwdata[WORD_W-1:0];
          REG_TRIGGER_LEVEL: trigger_level <= pwdata[WORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_BUFFER_WORDS:  prdata = {17'd0, buffer_words};
      REG_POST_TRIGGER:  prdata = {17'd0, post_trigger_words};
      REG_WIDE_MODE:     prdata = {31'd0, wide_mode};
      REG_TRIGGER_MASK:  prdata = {16'd0, trigger_mask};
      REG_TRIGGER_LEVEL: prdata = {16'd0, trigger_level};
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{
    buffer_words:       buffer_words,
    post_trigger_words: post_trigger_words,
    wide_mode:          wide_mode,
    trigger_mask:       trigger_mask,
    trigger_level:      trigger_level,
    budget_load:        budget_load
  };

endmodule

### hdl/lcrle_core.sv
// Input register, run state, trigger detection and ring pointer update.
module lcrle_core
  import lcrle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] sample,
  input  logic              slot_free,
  output logic              pair_load,
  output pair_t             pair
);

  localparam logic [LEN_W-1:0] RING_CAP =
    LEN_W'((STORE_DEPTH > RING_LIMIT) ? RING_LIMIT : STORE_DEPTH);

  // Input register.
  logic              iv;
  logic [WORD_W-1:0] isample;
  logic              go;

  // Run state.
  logic [WORD_W-1:0]  run_value;
  logic [COUNT_W-1:0] run_count;
  logic [ADDR_W-1:0]  write_pointer;
  logic signed [WORD_W-1:0] budget_left;
  logic               triggered;
  logic               finished;

  logic [WORD_W-1:0]  wmask, cur, prev, edges;
  logic [WORD_W-1:0]  flag;
  logic [COUNT_W-1:0] maxc, inc, cnt, cnt_sat;
  logic               fire, trig_now, same, emit, done;
  logic signed [WORD_W-1:0] budget_base, budget_next;
  logic [LEN_W-1:0]   ring_len, len_clip, step0, step1;
  logic [ADDR_W-1:0]  addr0, addr1, pointer_next;

  assign go       = iv && slot_free;
  assign in_stall = iv && !slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!in_stall) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      isample <= sample;
    end
  end

  always_comb begin
    wmask = cfg.wide_mode ? MASK_WIDE : MASK_NARROW;
    flag  = cfg.wide_mode ? FLAG_WIDE : FLAG_NARROW;
    maxc  = cfg.wide_mode ? MAX_WIDE  : MAX_NARROW;
    cur   = isample & wmask;
    prev  = run_value & wmask;

    // A masked bit that moves to its trigger level.
    edges    = ((~prev & cur & cfg.trigger_level) | (prev & ~cur & ~cfg.trigger_level))
               & cfg.trigger_mask & wmask;
    fire     = !triggered && (edges != '0);
    trig_now = triggered || fire;

    same    = (cur == run_value);
    inc     = run_count + COUNT_W'(1);
    emit    = !same || (inc >= maxc);
    cnt     = same ? inc : run_count;
    cnt_sat = (cnt > maxc) ? maxc : cnt;

    // A fresh post-trigger length takes effect for the sample handled in the same cycle.
    budget_base = (fire || cfg.budget_load) ? $signed({1'b0, cfg.post_trigger_words})
                                            : budget_left;
    budget_next = budget_base - WORD_W'(2);
    done        = trig_now && (budget_next[WORD_W-1] || (budget_next == '0));

    len_clip = (cfg.buffer_words > RING_CAP) ? RING_CAP : cfg.buffer_words;
    ring_len = (len_clip < LEN_W'(2)) ? LEN_W'(2) : len_clip;

    addr0        = ({1'b0, write_pointer} >= ring_len) ? '0 : write_pointer;
    step0        = {1'b0, addr0} + LEN_W'(1);
    addr1        = (step0 >= ring_len) ? '0 : step0[ADDR_W-1:0];
    step1        = {1'b0, addr1} + LEN_W'(1);
    pointer_next = (step1 >= ring_len) ? '0 : step1[ADDR_W-1:0];
  end

  assign pair_load = go && !finished && emit;

  assign pair = '{
    value_addr: addr0,
    count_addr: addr1,
    value_word: run_value,
    count_word: {1'b0, cnt_sat} | flag,
    done:       done
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value     <= '0;
      run_count     <= '0;
      write_pointer <= '0;
      budget_left   <= '0;
      triggered     <= 1'b0;
      finished      <= 1'b0;
    end else if (go && !finished) begin
      triggered <= trig_now;
      if (!same) begin
        run_value <= cur;
      end
      run_count <= emit ? '0 : inc;
      if (emit) begin
        write_pointer <= pointer_next;
        finished      <= done;
        budget_left   <= trig_now ? budget_next : budget_base;
      end else begin
        budget_left <= budget_base;
      end
    end else if (cfg.budget_load) begin
      budget_left <= $signed({1'b0, cfg.post_trigger_words});
    end
  end

endmodule

### hdl/lcrle_out.sv
// Result register holding one pair and sending it as two words.
module lcrle_out
  import lcrle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pair_load,
  input  pair_t             pair,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] store_addr,
  output logic [WORD_W-1:0] store_word,
  output logic              word_kind,
  output logic              last,
  output logic              capture_done
);

  logic  held;
  logic  phase;
  pair_t slot;
  logic  out_fire;

  assign out_fire  = held && !out_stall;
  assign slot_free = !held || (phase && out_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      phase <= 1'b0;
    end else if (pair_load) begin
      held  <= 1'b1;
      phase <= 1'b0;
    end else if (out_fire) begin
      if (phase) begin
        held  <= 1'b0;
        phase <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_load) begin
      slot <= pair;
    end
  end

  assign out_valid    = held;
  assign store_addr   = phase ? slot.count_addr : slot.value_addr;
  assign store_word   = phase ? slot.count_word : slot.value_word;
  assign word_kind    = phase;
  assign last         = phase;
  assign capture_done = slot.done;

endmodule

### hdl/logic_capture_rle_compressor.sv
// Top level of the logic capture run-length compressor.
//
//   Channel   Direction  Handshake             Payload
//   sample    in         in_valid / in_stall   sample
//   store     out        out_valid / out_stall store_addr, store_word, word_kind,
//                                              last, capture_done
//   config    in         APB psel / penable    paddr, pwdata, prdata
//
// A sample is taken into an input register; from there the run state, trigger
// detector and ring pointer are updated in one step once the result register is free.
// A sample that closes a run loads a pair into the result register, which sends the
// value word and then the count word, so such a sample occupies the store side
// for both words; samples that only extend a run go through at one per cycle while
// the result register is free, so the store side sets the rate: one sample per
// cycle while no pair is held. A stall on the store side holds the pair in place
// and backs up into in_stall once the input register is also full.
// Reset is synchronous and clears the run state, the pointer, the trigger and
// the settings to their default values. Once the post-trigger budget is spent
// every further sample is taken and dropped.
module logic_capture_rle_compressor
  import lcrle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  store_addr,
  output logic [WORD_W-1:0]  store_word,
  output logic               word_kind,
  output logic               last,
  output logic               capture_done
);

  cfg_t  cfg;
  pair_t pair;
  logic  pair_load;
  logic  slot_free;

  // Settings registers; a write of the post-trigger length also reloads the budget.
  lcrle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Run tracking: compares each sample with the current run and decides when
  // a value and count pair has to be written to the ring.
  lcrle_core #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .slot_free (slot_free),
    .pair_load (pair_load),
    .pair      (pair)
  );

  // Pair register; it frees itself in the cycle its count word is taken.
  lcrle_out u_out (
    .clk          (clk),
    .rst          (rst),
    .pair_load    (pair_load),
    .pair         (pair),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .store_addr   (store_addr),
    .store_word   (store_word),
    .word_kind    (word_kind),
    .last         (last),
    .capture_done (capture_done)
  );

endmodule

### test/lcrle_store_checker.sv
// Checker that predicts and compares the store words of the run-length compressor.
`timescale 1ns / 100ps
module lcrle_store_checker
  import lcrle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [WORD_W-1:0]  sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ADDR_W-1:0]  store_addr,
  input  logic [WORD_W-1:0]  store_word,
  input  logic               word_kind,
  input  logic               last,
  input  logic               capture_done,
  output int unsigned        mismatches,
  output int unsigned        words_waiting
);

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_COUNT  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              kind;
    logic              last;
    logic              done;
  } store_entry_t;

  store_entry_t awaited_words[$];

  logic [LEN_W-1:0]   ring_words;
  logic [LEN_W-1:0]   post_words;
  logic               wide;
  logic [WORD_W-1:0]  trig_mask;
  logic [WORD_W-1:0]  trig_level;
  logic [WORD_W-1:0]  run_value;
  logic [COUNT_W-1:0] run_count;
  int unsigned        write_ptr;
  int                 budget;
  logic               triggered;
  logic               finished;
  int unsigned        mismatch_total = 0;

  assign mismatches = mismatch_total;

  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("%0t: store mismatch: %s", $time, what);
  endtask

  function automatic int unsigned ring_length();
    int unsigned cap;
    int unsigned n;
    cap = (STORE_DEPTH < RING_LIMIT) ? STORE_DEPTH : RING_LIMIT;
    if (cap < 2) cap = 2;
    n = ring_words;
    if (n > cap) n = cap;
    if (n < 2) n = 2;
    return n;
  endfunction

  // The pointer advances after every word and wraps at the ring length, so a pair may straddle the end of the ring.
  function automatic logic [ADDR_W-1:0] take_ring_slot();
    int unsigned slot;
    int unsigned n;
    n = ring_length();
    slot = (write_ptr >= n) ? 0 : write_ptr;
    write_ptr = (slot + 1 >= n) ? 0 : slot + 1;
    return slot[ADDR_W-1:0];
  endfunction

  task automatic apply_register(input logic [2:0] index, input logic [31:0] data);
    case (index)
      REG_BUFFER_WORDS: ring_words = data[LEN_W-1:0];
      REG_POST_TRIGGER: begin
        post_words = data[LEN_W-1:0] & POST_TRIGGER_MASK;
        budget = post_words;
      end
      REG_WIDE_MODE:     wide = data[0];
      REG_TRIGGER_MASK:  trig_mask = data[WORD_W-1:0];
      REG_TRIGGER_LEVEL: trig_level = data[WORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic compress_sample(input logic [WORD_W-1:0] value);
    logic [WORD_W-1:0]  width_mask;
    logic [WORD_W-1:0]  flag;
    logic [WORD_W-1:0]  cur;
    logic [WORD_W-1:0]  prev;
    logic [WORD_W-1:0]  old_value;
    logic [WORD_W-1:0]  fire;
    logic [COUNT_W-1:0] count_limit;
    logic [COUNT_W-1:0] count;
    logic               emit;
    logic               done;
    store_entry_t       entry;
    if (finished) return;
    width_mask = wide ? MASK_WIDE : MASK_NARROW;
    flag = wide ? FLAG_WIDE : FLAG_NARROW;
    count_limit = wide ? MAX_WIDE : MAX_NARROW;
    cur = value & width_mask;
    prev = run_value & width_mask;
    old_value = run_value;
    emit = 1'b0;
    done = 1'b0;
    if (!triggered) begin
      // A masked bit fires when it moves to its level: rising for a one, falling for a zero.
      fire = ((~prev & cur & trig_level) | (prev & ~cur & ~trig_level)) & trig_mask & width_mask;
      if (fire != '0) begin
        triggered = 1'b1;
        budget = post_words;
      end
    end
    count = run_count;
    if (cur == run_value) begin
      run_count = run_count + 1'b1;
      count = run_count;
      if (run_count >= count_limit) begin
        emit = 1'b1;
        run_count = '0;
      end
    end else begin
      emit = 1'b1;
      run_count = '0;
      run_value = cur;
    end
    if (!emit) return;
    if (count > count_limit) count = count_limit;
    if (triggered) begin
      budget -= 2;
      if (budget <= 0) begin
        done = 1'b1;
        finished = 1'b1;
      end
    end
    entry.addr = take_ring_slot();
    entry.data = old_value;
    entry.kind = KIND_VALUE;
    entry.last = 1'b0;
    entry.done = done;
    awaited_words.push_back(entry);
    entry.addr = take_ring_slot();
    entry.data = {1'b0, count} | flag;
    entry.kind = KIND_COUNT;
    entry.last = 1'b1;
    entry.done = done;
    awaited_words.push_back(entry);
  endtask

  task automatic check_word();
    store_entry_t want;
    if (awaited_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word addr %0d data %h kind %b last %b done %b",
                                store_addr, store_word, word_kind, last, capture_done));
    end else begin
      want = awaited_words.pop_front();
      if (store_addr !== want.addr || store_word !== want.data || word_kind !== want.kind ||
          last !== want.last || capture_done !== want.done) begin
        report_mismatch($sformatf(
          "got addr %0d data %h kind %b last %b done %b, want %0d %h %b %b %b",
          store_addr, store_word, word_kind, last, capture_done,
          want.addr, want.data, want.kind, want.last, want.done));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ring_words = BUFFER_WORDS_RESET;
      post_words = '0;
      wide = 1'b1;
      trig_mask = '0;
      trig_level = '0;
      run_value = '0;
      run_count = '0;
      write_ptr = 0;
      budget = 0;
      triggered = 1'b0;
      finished = 1'b0;
      awaited_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) apply_register(paddr[PADDR_W-1:2], pwdata);
      if (in_valid === 1'b1 && in_stall === 1'b0) compress_sample(sample);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_word();
    end
    words_waiting <= awaited_words.size();
  end

endmodule

### test/logic_capture_rle_compressor_test.sv
// Top of the run-length compressor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module logic_capture_rle_compressor_test;
  import lcrle_pkg::*;

  localparam int STORE_DEPTH   = STORE_DEPTH_DEFAULT;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS   = 80;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [WORD_W-1:0]  sample;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  store_addr;
  logic [WORD_W-1:0]  store_word;
  logic               word_kind;
  logic               last;
  logic               capture_done;

  int unsigned mismatches;
  int unsigned words_waiting;

  // Pacing. The gap rate is only read by the stimulus process; the stall rate and the
  // hold-off requests are handed to the receiver process through nonblocking writes.
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   holds_wanted = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  logic wide_now = 1'b1;

  logic_capture_rle_compressor #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .store_addr  (store_addr),
    .store_word  (store_word),
    .word_kind   (word_kind),
    .last        (last),
    .capture_done(capture_done)
  );

  lcrle_store_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .store_addr   (store_addr),
    .store_word   (store_word),
    .word_kind    (word_kind),
    .last         (last),
    .capture_done (capture_done),
    .mismatches   (mismatches),
    .words_waiting(words_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Overall time limit, far beyond the slowest correct run of about twelve hundred
  // samples under heavy stalls and the long hold-off.
  initial begin
    #(64'd3_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver. A pending hold-off request takes precedence and keeps the store side stalled
  // for a fixed stretch, counted here, so that the block fills up and pushes back on its
  // input. Otherwise the stall follows the rate of the current phase.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_wanted != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic set_pace(input int gap, input int stall);
    gap_pct = gap;
    stall_pct <= stall;
  endtask

  // One APB write: setup cycle, then the access cycle, then an idle cycle so that the next
  // write never lowers and raises psel in the same step.
  task automatic apb_write(input logic [2:0] index, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering words and wait until every expected store word has come out. The extra
  // cycles cover a sample that only extends a run and is still in the input register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] ring, input logic [31:0] post,
                                input logic [31:0] wide, input logic [31:0] mask,
                                input logic [31:0] level);
    settle();
    apb_write(REG_BUFFER_WORDS, ring);
    apb_write(REG_POST_TRIGGER, post);
    apb_write(REG_WIDE_MODE, wide);
    apb_write(REG_TRIGGER_MASK, mask);
    apb_write(REG_TRIGGER_LEVEL, level);
    wide_now = wide[0];
  endtask

  // Offer one sample word, with idle cycles before it at the rate of the phase, and hold
  // it until the block takes it.
  task automatic send_word(input logic [WORD_W-1:0] value);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // A run of equal samples. In narrow mode the upper byte is noise that must be ignored.
  task automatic send_run(input logic [WORD_W-1:0] value, input int n);
    logic [7:0] noise;
    repeat (n) begin
      noise = 8'($urandom);
      send_word(wide_now ? value : {noise, value[7:0]});
    end
  endtask

  // Random runs: mostly short, some medium, and now and then long enough to cross the
  // narrow-mode count limit. A small palette makes repeated values across runs likely.
  task automatic send_random(input int n);
    logic [WORD_W-1:0] palette [4];
    logic [WORD_W-1:0] value;
    int                sent;
    int                len;
    int                pick;
    sent = 0;
    foreach (palette[i]) palette[i] = 16'($urandom);
    while (sent < n) begin
      case ($urandom_range(9)) inside
        0:       value = 16'h0000;
        1:       value = 16'hffff;
        [2:4]:   value = 16'($urandom);
        default: value = palette[$urandom_range(3)];
      endcase
      pick = $urandom_range(99);
      if (pick < 75) len = $urandom_range(3, 1);
      else if (pick < 97) len = $urandom_range(20, 4);
      else len = $urandom_range(135, 120);
      send_run(value, len);
      sent += len;
    end
  endtask

  initial begin
    int phase;
    logic [31:0] post;
    logic [31:0] mask;
    logic [31:0] level;
    logic [31:0] wide;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    sample <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words with the reset settings: wide mode, full ring, no trigger. The first
    // two zeros extend the reset run, then the field extremes each close a run.
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(16'hffff);
    send_word(16'hffff);
    send_word(16'h8000);
    send_word(16'h7fff);
    send_word(16'h0001);
    send_word(16'h0001);
    send_word(16'h0001);
    send_word(16'hfffe);
    // An odd ring length, so that a pair splits across the end of the ring.
    apply_settings(3, 0, 1, 0, 0);
    send_word(16'h1111);
    send_word(16'h2222);
    send_word(16'h3333);
    send_word(16'h4444);
    // A length below the minimum falls back to two words.
    apply_settings(0, 0, 1, 0, 0);
    send_word(16'h00ff);
    send_word(16'h0100);
    // Narrow mode: only the low byte counts, so the first three words form one run.
    apply_settings(16384, 0, 0, 0, 0);
    send_word(16'h12ff);
    send_word(16'habff);
    send_word(16'h00ff);
    send_word(16'h0100);
    send_word(16'h80ff);

    // Random phases cycle through the four pacing schemes. The trigger mask stays clear,
    // or points only at upper bits in narrow mode where they cannot fire, because the end
    // of a capture is final and is kept for the last phase.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       set_pace(0, 0);
        1:       set_pace(57, 0);
        2:       set_pace(0, 57);
        default: set_pace(20, 20);
      endcase
      post = $urandom;
      level = $urandom;
      case (phase)
        // Out-of-range length and budget.
        0: apply_settings(32'hffff_ffff, 32'hffff_ffff, 1, 0, 32'h0000_ffff);
        1: apply_settings(5, post, 0, 32'h0000_ff00, 32'h0000_ffff);
        2: begin
          apply_settings(2, 0, 0, 0, 0);
          holds_wanted <= holds_wanted + 1;
        end
        3: begin
          // A long wide run that is still open when the mode drops to narrow: the next
          // equal sample must emit at once with the count held at the narrow maximum.
          apply_settings(16384, post, 1, 0, level);
          send_run(16'h00a5, 200);
          apply_settings($urandom_range(40, 2), post, 0, 0, level);
          send_run(16'h12a5, 1);
        end
        4: apply_settings($urandom_range(32'h7fff), post, 1, 0, level);
        5: apply_settings(16384, 32'h0000_7fff, 1, 0, 0);
        6: apply_settings($urandom_range(99, 3) | 1, post, 0, 0, level);
        default: apply_settings(1, post, 1, 0, 0);
      endcase
      send_random(PHASE_WORDS);
    end

    // Trigger phase. A small budget, sometimes none at all, so the capture ends within the
    // phase; the words after the end must be taken and dropped.
    set_pace(20, 20);
    post = ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(60, 2);
    wide = $urandom_range(1);
    mask = ($urandom_range(1) == 0) ? 32'h0000_ffff : $urandom_range(32'hffff, 1);
    mask = mask | (32'h1 << $urandom_range(7));
    case ($urandom_range(2))
      0:       level = 32'h0000_0000;
      1:       level = 32'h0000_ffff;
      default: level = $urandom;
    endcase
    apply_settings($urandom_range(64, 2), post, wide, mask, level);
    send_random(300);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && words_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
